// File: src/jsrc_pkg.sv
package jsrc_pkg;

    localparam int CODE_W      = 12;
    localparam int GAIN_W      = 16;
    localparam int DB_W        = 16;
    localparam int LIM_W       = 8;
    localparam int ANGLE_W     = 26;
    localparam int WORD_W      = 16;
    localparam int NOTE_IDX_W  = 5;
    localparam int DIGIT_W     = 4;
    localparam int NDIG        = GAIN_W / DIGIT_W;
    localparam int DCNT_W      = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int DIFF_W      = CODE_W + 1;
    localparam int PP_W        = DIFF_W + DIGIT_W + 1;
    localparam int PROD_W      = DIFF_W + GAIN_W + 1;
    localparam int FRAC_SHIFT  = 8;
    localparam int STEP_W      = PROD_W - FRAC_SHIFT;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 5;
    localparam int REG_IDX_W   = APB_AW - 2;

    localparam int UPDATE_SKIP_PERIOD_DEF = 1000;
    localparam int NOTE_SAMPLES_DEF       = 125;
    localparam int NOTE_COUNT_DEF         = 25;

    localparam logic [REG_IDX_W-1:0] REG_CENTER_A = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_B = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_A   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_B   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_B  = 3'd5;

    localparam logic [CODE_W-1:0] CENTER_A_RST = 12'd2314;
    localparam logic [CODE_W-1:0] CENTER_B_RST = 12'd2205;
    localparam logic [GAIN_W-1:0] GAIN_A_RST   = 16'd1813;
    localparam logic [GAIN_W-1:0] GAIN_B_RST   = 16'd1902;
    localparam logic [DB_W-1:0]   DEADBAND_RST = 16'd328;
    localparam logic [LIM_W-1:0]  LIMIT_B_RST  = 8'd10;
    localparam logic [WORD_W-1:0] PERIOD_RST   = 16'd10000;

    localparam logic signed [ANGLE_W-1:0] DEG_90     = 26'sd5898240;
    localparam logic signed [ANGLE_W-1:0] NEG_DEG_90 = -26'sd5898240;
    localparam logic signed [31:0]        SERVO_SLOPE = 32'sd27;
    localparam logic signed [31:0]        SERVO_MID   = 32'sd327680000;

    typedef struct packed {
        logic [CODE_W-1:0] code_a;
        logic [CODE_W-1:0] code_b;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] compare_a;
        logic [WORD_W-1:0] compare_b;
        logic              buzzer_on;
        logic [WORD_W-1:0] tone_period;
        logic              tone_load;
    } t_out_word;

    function automatic logic signed [ANGLE_W-1:0] clamp90(
        input logic signed [ANGLE_W-1:0] a
    );
        logic signed [ANGLE_W-1:0] c;
        c = a;
        if (a > DEG_90) begin
            c = DEG_90;
        end else if (a < NEG_DEG_90) begin
            c = NEG_DEG_90;
        end
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] servo_word(input logic signed [ANGLE_W-1:0] a);
        logic signed [ANGLE_W-1:0] c;
        logic signed [31:0]        v;
        c = clamp90(a);
        v = 32'(c) * SERVO_SLOPE + SERVO_MID;
        return v[31:16];
    endfunction

    // one radix-16 digit of the gain, most significant first
    function automatic logic signed [PROD_W-1:0] mac_digit(
        input logic signed [PROD_W-1:0] acc,
        input logic signed [DIFF_W-1:0] diff,
        input logic [DIGIT_W-1:0]       digit
    );
        logic signed [PP_W-1:0] pp;
        pp = diff * $signed({1'b0, digit});
        return (acc <<< DIGIT_W) + {{(PROD_W-PP_W){pp[PP_W-1]}}, pp};
    endfunction

    function automatic logic signed [ANGLE_W-1:0] apply_deadband(
        input logic signed [PROD_W-1:0] prod,
        input logic [DB_W-1:0]          db
    );
        logic signed [STEP_W-1:0] s;
        logic signed [STEP_W-1:0] dbs;
        s   = prod[PROD_W-1:FRAC_SHIFT];
        dbs = $signed({{(STEP_W-DB_W){1'b0}}, db});
        if (s < dbs && s > -dbs) begin
            s = '0;
        end
        return {{(ANGLE_W-STEP_W){s[STEP_W-1]}}, s};
    endfunction

    function automatic logic [WORD_W-1:0] melody_note(input logic [NOTE_IDX_W-1:0] idx);
        logic [WORD_W-1:0] p;
        unique case (idx)
            5'd0, 5'd1:   p = 16'd18958;
            5'd2, 5'd3:   p = 16'd21204;
            5'd4, 5'd5:   p = 16'd33860;
            5'd6, 5'd7:   p = 16'd30189;
            5'd8, 5'd9:   p = 16'd22606;
            5'd10, 5'd11: p = 16'd25252;
            5'd12, 5'd13: p = 16'd42566;
            5'd14, 5'd15: p = 16'd37922;
            5'd16, 5'd17: p = 16'd25252;
            5'd18, 5'd19: p = 16'd28409;
            5'd20, 5'd21: p = 16'd45018;
            5'd22, 5'd23: p = 16'd37922;
            5'd24:        p = 16'd28409;
            default:      p = PERIOD_RST;
        endcase
        return p;
    endfunction

endpackage

// File: src/jsrc_in_if.sv
interface jsrc_in_if;
    import jsrc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: src/jsrc_out_if.sv
interface jsrc_out_if;
    import jsrc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: src/joystick_servo_rate_control.sv
// A word is accepted, then its step products run one 4-bit gain digit per cycle
// in S_MUL, S_ADD adds the steps to the held angles (unless the sample phase is
// zero), and S_OUT loads the output register, holding while it is full and untaken.
// The next word is taken in the result cycle while the output register is free.
// Reset (synchronous, active low): registers to defaults, angles and counters zero.
module joystick_servo_rate_control #(
    parameter int UPDATE_SKIP_PERIOD = jsrc_pkg::UPDATE_SKIP_PERIOD_DEF,
    parameter int NOTE_SAMPLES       = jsrc_pkg::NOTE_SAMPLES_DEF,
    parameter int NOTE_COUNT         = jsrc_pkg::NOTE_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    jsrc_in_if.sink                     i_in,
    jsrc_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jsrc_pkg::APB_AW-1:0] paddr,
    input  logic [jsrc_pkg::APB_DW-1:0] pwdata,
    output logic [jsrc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import jsrc_pkg::*;

    localparam int PHASE_W = $clog2(UPDATE_SKIP_PERIOD);
    localparam int NPH_W   = $clog2(NOTE_SAMPLES + 1);
    localparam logic [WORD_W-1:0] STOP_COMPARE = servo_word(DEG_90);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [CODE_W-1:0]         r_center_a, r_center_b;
    logic [GAIN_W-1:0]         r_gain_a, r_gain_b;
    logic [DB_W-1:0]           r_deadband;
    logic [LIM_W-1:0]          r_limit_b;
    logic signed [ANGLE_W-1:0] r_angle_a, r_angle_b;
    logic [PHASE_W-1:0]        r_phase;
    logic [NPH_W-1:0]          r_note_phase;
    logic [NOTE_IDX_W-1:0]     r_note_idx;
    logic [WORD_W-1:0]         r_period;
    logic                      r_out_valid;
    t_out_word                 r_out;
    logic [DCNT_W-1:0]         r_dcnt;
    logic signed [DIFF_W-1:0]  r_diff_a, r_diff_b;
    logic [GAIN_W-1:0]         r_gsr_a, r_gsr_b;
    logic signed [PROD_W-1:0]  r_acc_a, r_acc_b;

    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      cfg_idx;
    logic                      out_free;
    logic                      accept;
    logic                      load_out;
    logic signed [ANGLE_W-1:0] lim_b;
    logic signed [ANGLE_W-1:0] clamp_b;
    logic signed [ANGLE_W-1:0] step_a, step_b;
    logic                      at_stop, buzz, tone_hit, phase_last;
    logic [NOTE_IDX_W-1:0]     idx_base;
    logic [NOTE_IDX_W-1:0]     n_note_idx;
    logic [WORD_W-1:0]         n_period;
    logic [PHASE_W-1:0]        n_phase;
    logic [NPH_W-1:0]          n_note_phase;
    t_out_word                 n_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_comb begin
        unique case (cfg_idx)
            REG_CENTER_A: prdata = APB_DW'(r_center_a);
            REG_CENTER_B: prdata = APB_DW'(r_center_b);
            REG_GAIN_A:   prdata = APB_DW'(r_gain_a);
            REG_GAIN_B:   prdata = APB_DW'(r_gain_b);
            REG_DEADBAND: prdata = APB_DW'(r_deadband);
            REG_LIMIT_B:  prdata = APB_DW'(r_limit_b);
            default:      prdata = '0;
        endcase
    end

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) || ((r_state == S_OUT) && out_free);
    assign accept      = i_in.valid && i_in.ready;
    assign load_out    = (r_state == S_OUT) && out_free;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        lim_b   = {{(ANGLE_W-LIM_W-16){r_limit_b[LIM_W-1]}}, r_limit_b, 16'b0};
        clamp_b = (r_angle_b > lim_b) ? lim_b : r_angle_b;
        if (clamp_b < NEG_DEG_90) begin
            clamp_b = NEG_DEG_90;
        end
        step_a = apply_deadband(r_acc_a, r_deadband);
        step_b = apply_deadband(r_acc_b, r_deadband);
    end

    always_comb begin
        at_stop    = (r_angle_b == NEG_DEG_90);
        buzz       = at_stop && ({1'b0, r_note_idx} < (NOTE_IDX_W+1)'(NOTE_COUNT));
        idx_base   = buzz ? r_note_idx : '0;
        tone_hit   = at_stop && (r_note_phase == '0);
        n_note_idx = tone_hit ? idx_base + NOTE_IDX_W'(1) : idx_base;
        n_period   = tone_hit ? melody_note(idx_base) : r_period;
        phase_last = (r_phase == PHASE_W'(UPDATE_SKIP_PERIOD - 1));
        n_phase    = phase_last ? '0 : r_phase + PHASE_W'(1);
        if (phase_last || r_note_phase == NPH_W'(NOTE_SAMPLES - 1)) begin
            n_note_phase = '0;
        end else begin
            n_note_phase = r_note_phase + NPH_W'(1);
        end
        n_out.compare_a   = servo_word(r_angle_a);
        n_out.compare_b   = servo_word(-r_angle_b);
        n_out.buzzer_on   = buzz;
        n_out.tone_period = n_period;
        n_out.tone_load   = tone_hit;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_MUL;
            end
            S_MUL: begin
                if (r_dcnt == DCNT_W'(NDIG - 1)) n_state = S_ADD;
            end
            S_ADD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (load_out) n_state = accept ? S_MUL : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_center_a   <= CENTER_A_RST;
            r_center_b   <= CENTER_B_RST;
            r_gain_a     <= GAIN_A_RST;
            r_gain_b     <= GAIN_B_RST;
            r_deadband   <= DEADBAND_RST;
            r_limit_b    <= LIMIT_B_RST;
            r_angle_a    <= '0;
            r_angle_b    <= '0;
            r_phase      <= '0;
            r_note_phase <= '0;
            r_note_idx   <= '0;
            r_period     <= PERIOD_RST;
            r_out_valid  <= 1'b0;
            r_dcnt       <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_CENTER_A: r_center_a <= pwdata[CODE_W-1:0];
                    REG_CENTER_B: r_center_b <= pwdata[CODE_W-1:0];
                    REG_GAIN_A:   r_gain_a   <= pwdata[GAIN_W-1:0];
                    REG_GAIN_B:   r_gain_b   <= pwdata[GAIN_W-1:0];
                    REG_DEADBAND: r_deadband <= pwdata[DB_W-1:0];
                    REG_LIMIT_B:  r_limit_b  <= pwdata[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_dcnt <= '0;
            end else if (r_state == S_MUL) begin
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            // clamp the held angles before this word's step lands
            if (r_state == S_MUL && r_dcnt == '0) begin
                r_angle_a <= clamp90(r_angle_a);
                r_angle_b <= clamp_b;
            end
            if (r_state == S_ADD && r_phase != '0) begin
                r_angle_a <= r_angle_a + step_a;
                r_angle_b <= r_angle_b + step_b;
            end
            if (load_out) begin
                r_note_idx   <= n_note_idx;
                r_period     <= n_period;
                r_phase      <= n_phase;
                r_note_phase <= n_note_phase;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff_a <= $signed({1'b0, i_in.data.code_a}) - $signed({1'b0, r_center_a});
            r_diff_b <= $signed({1'b0, i_in.data.code_b}) - $signed({1'b0, r_center_b});
            r_gsr_a  <= r_gain_a;
            r_gsr_b  <= r_gain_b;
            r_acc_a  <= '0;
            r_acc_b  <= '0;
        end else if (r_state == S_MUL) begin
            r_acc_a <= mac_digit(r_acc_a, r_diff_a, r_gsr_a[GAIN_W-1 -: DIGIT_W]);
            r_acc_b <= mac_digit(r_acc_b, r_diff_b, r_gsr_b[GAIN_W-1 -: DIGIT_W]);
            r_gsr_a <= r_gsr_a << DIGIT_W;
            r_gsr_b <= r_gsr_b << DIGIT_W;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    a_buzz_at_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.buzzer_on |-> o_out.data.compare_b == STOP_COMPARE)
        else $error("buzzer driven away from the lower stop");

    a_angle_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADD |-> r_angle_a <= DEG_90 && r_angle_a >= NEG_DEG_90
                             && r_angle_b >= NEG_DEG_90)
        else $error("held angle not clamped before step");

    a_phase_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == '0 |-> r_note_phase == '0)
        else $error("note phase out of step with sample phase");

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsrc_pkg::*;

    localparam int     SKIP_PERIOD  = UPDATE_SKIP_PERIOD_DEF;
    localparam int     NOTE_LEN     = NOTE_SAMPLES_DEF;
    localparam int     NOTE_TOTAL   = NOTE_COUNT_DEF;
    localparam longint DEG90_Q16    = 64'sd5898240;
    localparam longint SLOPE_Q      = 64'sd27;
    localparam longint MID_Q16      = 64'sd327680000;
    localparam int     RANDOM_WORDS = 480;
    localparam int     MELODY_HOLD  = 300;

    localparam logic [REG_IDX_W-1:0] REG_NONE_6 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_NONE_7 = 3'd7;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    jsrc_in_if  in_bus();
    jsrc_out_if out_bus();

    joystick_servo_rate_control DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [WORD_W-1:0] tune_tbl [0:31] = '{
        16'd18958, 16'd18958, 16'd21204, 16'd21204, 16'd33860, 16'd33860, 16'd30189, 16'd30189,
        16'd22606, 16'd22606, 16'd25252, 16'd25252, 16'd42566, 16'd42566, 16'd37922, 16'd37922,
        16'd25252, 16'd25252, 16'd28409, 16'd28409, 16'd45018, 16'd45018, 16'd37922, 16'd37922,
        16'd28409, 16'd10000, 16'd10000, 16'd10000, 16'd10000, 16'd10000, 16'd10000, 16'd10000
    };

    logic [CODE_W-1:0]          cfg_center_a;
    logic [CODE_W-1:0]          cfg_center_b;
    logic [GAIN_W-1:0]          cfg_gain_a;
    logic [GAIN_W-1:0]          cfg_gain_b;
    logic [DB_W-1:0]            cfg_deadband;
    logic signed [LIM_W-1:0]    cfg_limit_b;
    logic signed [ANGLE_W-1:0]  ang_a;
    logic signed [ANGLE_W-1:0]  ang_b;
    logic [9:0]                 phase;
    logic [NOTE_IDX_W-1:0]      note_idx;
    logic [WORD_W-1:0]          tone_hold;

    t_out_word due_outputs[$];
    int        fail_cnt;
    int        words_sent;
    bit        flat_out;

    function automatic longint axis_rate(input logic [CODE_W-1:0] code,
                                         input logic [CODE_W-1:0] ctr,
                                         input logic [GAIN_W-1:0] g);
        longint s;
        s = ((longint'(code) - longint'(ctr)) * longint'(g)) >>> 8;
        if (s < longint'(cfg_deadband) && s > -longint'(cfg_deadband)) begin
            s = 0;
        end
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] servo_cmp(input longint a);
        longint c;
        c = a;
        if (a > DEG90_Q16) begin
            c = DEG90_Q16;
        end else if (a < -DEG90_Q16) begin
            c = -DEG90_Q16;
        end
        return WORD_W'((SLOPE_Q * c + MID_Q16) >>> 16);
    endfunction

    function automatic t_out_word servo_tone_next(input t_in_word w);
        longint    step_a;
        longint    step_b;
        longint    top_b;
        t_out_word r;
        step_a = axis_rate(w.code_a, cfg_center_a, cfg_gain_a);
        step_b = axis_rate(w.code_b, cfg_center_b, cfg_gain_b);
        top_b  = longint'(cfg_limit_b) * 65536;
        if (ang_a > DEG90_Q16) begin
            ang_a = ANGLE_W'(DEG90_Q16);
        end else if (ang_a < -DEG90_Q16) begin
            ang_a = ANGLE_W'(-DEG90_Q16);
        end
        if (ang_b > top_b) begin
            ang_b = ANGLE_W'(top_b);
        end
        if (ang_b < -DEG90_Q16) begin
            ang_b = ANGLE_W'(-DEG90_Q16);
        end
        if (phase != 0) begin
            ang_a = ANGLE_W'(longint'(ang_a) + step_a);
            ang_b = ANGLE_W'(longint'(ang_b) + step_b);
        end
        r = '0;
        r.compare_a = servo_cmp(longint'(ang_a));
        r.compare_b = servo_cmp(-longint'(ang_b));
        if (longint'(ang_b) == -DEG90_Q16) begin
            if (note_idx < NOTE_TOTAL) begin
                r.buzzer_on = 1'b1;
            end else begin
                note_idx = '0;
            end
            if (phase % NOTE_LEN == 0) begin
                tone_hold   = tune_tbl[note_idx];
                note_idx    = note_idx + 1'b1;
                r.tone_load = 1'b1;
            end
        end else begin
            note_idx = '0;
        end
        phase = (phase == SKIP_PERIOD - 1) ? '0 : phase + 1'b1;
        r.tone_period = tone_hold;
        return r;
    endfunction

    function automatic logic [APB_DW-1:0] field_mask(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_CENTER_A, REG_CENTER_B:          return 32'h0000_0FFF;
            REG_GAIN_A, REG_GAIN_B, REG_DEADBAND: return 32'h0000_FFFF;
            REG_LIMIT_B:                         return 32'h0000_00FF;
            default:                             return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [APB_DW-1:0] reg_image(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_CENTER_A: return APB_DW'(cfg_center_a);
            REG_CENTER_B: return APB_DW'(cfg_center_b);
            REG_GAIN_A:   return APB_DW'(cfg_gain_a);
            REG_GAIN_B:   return APB_DW'(cfg_gain_b);
            REG_DEADBAND: return APB_DW'(cfg_deadband);
            REG_LIMIT_B:  return APB_DW'(unsigned'(cfg_limit_b));
            default:      return '0;
        endcase
    endfunction

    function automatic void cfg_store(input logic [REG_IDX_W-1:0] idx,
                                      input logic [APB_DW-1:0] data);
        case (idx)
            REG_CENTER_A: cfg_center_a = data[CODE_W-1:0];
            REG_CENTER_B: cfg_center_b = data[CODE_W-1:0];
            REG_GAIN_A:   cfg_gain_a   = data[GAIN_W-1:0];
            REG_GAIN_B:   cfg_gain_b   = data[GAIN_W-1:0];
            REG_DEADBAND: cfg_deadband = data[DB_W-1:0];
            REG_LIMIT_B:  cfg_limit_b  = data[LIM_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic int idle_len();
        int r;
        if (flat_out) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [APB_DW-1:0] wide_pick(input int bits);
        int               r;
        logic [APB_DW-1:0] m;
        m = (bits >= 32) ? '1 : ((32'd1 << bits) - 1);
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return m;
        end
        return $urandom() & m;
    endfunction

    // pick a code of axis B that keeps the step inside the deadband
    function automatic logic [CODE_W-1:0] quiet_code_b();
        int c;
        c = int'(cfg_center_b) + int'($urandom_range(0, 4)) - 2;
        if (c < 0 || c > 4095 || axis_rate(c[CODE_W-1:0], cfg_center_b, cfg_gain_b) != 0) begin
            c = int'(cfg_center_b);
        end
        return c[CODE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (due_outputs.size() == 0) begin
                $display("%0t: servo word arrived with nothing expected", $time);
                fail_cnt++;
            end else begin
                want = due_outputs.pop_front();
                check_field("compare_a", want.compare_a, out_bus.data.compare_a);
                check_field("compare_b", want.compare_b, out_bus.data.compare_b);
                check_field("buzzer_on", want.buzzer_on, out_bus.data.buzzer_on);
                check_field("tone_period", want.tone_period, out_bus.data.tone_period);
                check_field("tone_load", want.tone_load, out_bus.data.tone_load);
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_bus.ready = 1'b0;
                stall--;
            end else begin
                out_bus.ready = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall = idle_len();
                end
            end
        end
    end

    task automatic push_sample(input logic [CODE_W-1:0] ca, input logic [CODE_W-1:0] cb);
        int       gap;
        t_in_word w;
        w.code_a = ca;
        w.code_b = cb;
        gap = idle_len();
        if (gap > 0) begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid = 1'b1;
        in_bus.data  = w;
        do @(posedge i_clk); while (!in_bus.ready);
        due_outputs.push_back(servo_tone_next(w));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_bus.valid = 1'b0;
        while (due_outputs.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] m;
        logic [APB_DW-1:0] data;
        m    = field_mask(idx);
        data = ($urandom() & ~m) | (value & m);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_store(idx, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apb_read_check(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DW-1:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        check_field($sformatf("register %0d", idx), reg_image(idx) & field_mask(idx),
                    got & field_mask(idx));
    endtask

    task automatic park_b();
        int n;
        n = 0;
        while (longint'(ang_b) > -DEG90_Q16 && n < 300) begin
            push_sample(CODE_W'($urandom_range(0, 4095)), '0);
            n++;
        end
    endtask

    task automatic hold_b(input int len);
        repeat (len) push_sample(CODE_W'($urandom_range(0, 4095)), quiet_code_b());
    endtask

    task automatic read_all_regs();
        for (int i = REG_CENTER_A; i <= REG_LIMIT_B; i++) begin
            apb_read_check(REG_IDX_W'(i));
        end
    endtask

    task automatic test_register_access();
        read_all_regs();
        apb_write(REG_CENTER_A, '0);
        apb_write(REG_CENTER_B, 32'h0000_0FFF);
        apb_write(REG_GAIN_A, 32'h0000_FFFF);
        apb_write(REG_GAIN_B, '0);
        apb_write(REG_DEADBAND, '0);
        apb_write(REG_LIMIT_B, 32'h0000_0080);
        apb_write(REG_NONE_6, $urandom());
        apb_write(REG_NONE_7, $urandom());
        read_all_regs();
        repeat (4) begin
            for (int i = REG_CENTER_A; i <= REG_LIMIT_B; i++) begin
                apb_write(REG_IDX_W'(i), $urandom());
            end
            read_all_regs();
        end
    endtask

    task automatic test_directed_extremes();
        apb_write(REG_CENTER_A, APB_DW'(CENTER_A_RST));
        apb_write(REG_CENTER_B, APB_DW'(CENTER_B_RST));
        apb_write(REG_GAIN_A, APB_DW'(GAIN_A_RST));
        apb_write(REG_GAIN_B, APB_DW'(GAIN_B_RST));
        apb_write(REG_DEADBAND, APB_DW'(DEADBAND_RST));
        apb_write(REG_LIMIT_B, APB_DW'(LIMIT_B_RST));
        push_sample('0, '0);
        push_sample('1, '1);
        push_sample(CENTER_A_RST, CENTER_B_RST);
        push_sample(CENTER_A_RST + 1'b1, CENTER_B_RST - 1'b1);
        // full gain, no deadband: A to the low stop, B past its upper limit
        wait_idle();
        apb_write(REG_CENTER_A, 32'h0000_0FFF);
        apb_write(REG_CENTER_B, '0);
        apb_write(REG_GAIN_A, 32'h0000_FFFF);
        apb_write(REG_GAIN_B, 32'h0000_FFFF);
        apb_write(REG_DEADBAND, '0);
        apb_write(REG_LIMIT_B, 32'h0000_007F);
        repeat (9) push_sample('0, '1);
        // upper limit below the low stop: low clamp wins; center zero on A
        wait_idle();
        apb_write(REG_LIMIT_B, 32'h0000_0080);
        apb_write(REG_CENTER_A, '0);
        apb_write(REG_CENTER_B, 32'h0000_0FFF);
        repeat (3) push_sample('1, '0);
        wait_idle();
        apb_write(REG_DEADBAND, 32'h0000_FFFF);
        push_sample('1, '0);
        push_sample('0, '1);
        push_sample(12'd2048, 12'd2048);
        wait_idle();
        apb_write(REG_LIMIT_B, 32'h0000_00A5);
        push_sample('1, '0);
        push_sample('0, '1);
    endtask

    task automatic test_melody_cycle();
        wait_idle();
        apb_write(REG_CENTER_A, 32'd2048);
        apb_write(REG_CENTER_B, 32'd2048);
        apb_write(REG_GAIN_A, APB_DW'(GAIN_A_RST));
        apb_write(REG_GAIN_B, 32'h0000_FFFF);
        apb_write(REG_DEADBAND, APB_DW'(DEADBAND_RST));
        apb_write(REG_LIMIT_B, APB_DW'(LIMIT_B_RST));
        park_b();
        hold_b(MELODY_HOLD);
        push_sample(CODE_W'($urandom_range(0, 4095)), '1);
        park_b();
        hold_b(100);
    endtask

    task automatic shuffle_config(input bit park);
        apb_write(REG_CENTER_A, wide_pick(CODE_W));
        apb_write(REG_GAIN_A, wide_pick(GAIN_W));
        if ($urandom_range(0, 9) < 5) begin
            apb_write(REG_DEADBAND, $urandom_range(0, 600));
        end else begin
            apb_write(REG_DEADBAND, wide_pick(DB_W));
        end
        apb_write(REG_LIMIT_B, wide_pick(LIM_W));
        if (park) begin
            apb_write(REG_CENTER_B, $urandom_range(2048, 4095));
            apb_write(REG_GAIN_B, $urandom_range(49152, 65535));
        end else begin
            apb_write(REG_CENTER_B, wide_pick(CODE_W));
            apb_write(REG_GAIN_B, wide_pick(GAIN_W));
        end
    endtask

    task automatic test_random_traffic();
        int start;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            bit park;
            park = ($urandom_range(0, 9) < 6);
            wait_idle();
            flat_out = ($urandom_range(0, 3) == 0);
            shuffle_config(park);
            if (park) begin
                park_b();
                hold_b($urandom_range(20, 250));
            end else begin
                repeat ($urandom_range(20, 80)) begin
                    push_sample(CODE_W'($urandom_range(0, 4095)),
                                CODE_W'($urandom_range(0, 4095)));
                end
            end
        end
        flat_out = 1'b0;
    endtask

    initial begin
        in_bus.valid = 1'b0;
        in_bus.data  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        flat_out     = 1'b0;
        fail_cnt     = 0;
        words_sent   = 0;
        cfg_center_a = CENTER_A_RST;
        cfg_center_b = CENTER_B_RST;
        cfg_gain_a   = GAIN_A_RST;
        cfg_gain_b   = GAIN_B_RST;
        cfg_deadband = DEADBAND_RST;
        cfg_limit_b  = LIMIT_B_RST;
        ang_a        = '0;
        ang_b        = '0;
        phase        = '0;
        note_idx     = '0;
        tone_hold    = PERIOD_RST;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_access();
        test_directed_extremes();
        test_melody_cycle();
        test_random_traffic();

        wait_idle();
        repeat (12) @(posedge i_clk);
        if (fail_cnt == 0 && due_outputs.size() == 0) begin
            $display("** joystick_servo_rate_control: PASSED **");
        end else begin
            $display("** joystick_servo_rate_control: FAILED **");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("** joystick_servo_rate_control: FAILED **");
        $finish;
    end

endmodule
